FILE: hw/rtl/udsdl_pkg.sv
// Shared types and constants for the UDS download session block.
`default_nettype none
package udsdl_pkg;
  localparam logic [1:0] CMD_DOWNLOAD = 2'd0;
  localparam logic [1:0] CMD_HEADER   = 2'd1;
  localparam logic [1:0] CMD_DATA     = 2'd2;
  localparam logic [1:0] CMD_EXIT     = 2'd3;

  localparam logic [7:0] SID_DOWNLOAD    = 8'h34;
  localparam logic [7:0] SID_TRANSFER    = 8'h36;
  localparam logic [7:0] SID_EXIT        = 8'h37;
  localparam logic [7:0] SID_NEGATIVE    = 8'h7F;
  localparam logic [7:0] POSITIVE_OFFSET = 8'h40;
  localparam logic [7:0] FORMAT_REQUIRED = 8'h44;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int unsigned DOWNLOAD_MIN_LENGTH = 11;
  localparam int unsigned EXIT_CRC_LENGTH = 5;

  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_ACTIVE   = 2'd1;
  localparam logic [1:0] PHASE_COMPLETE = 2'd2;
  localparam logic [1:0] PHASE_FAILED   = 2'd3;

  localparam logic [2:0] CODE_NONE         = 3'd0;
  localparam logic [2:0] CODE_RANGE        = 3'd1;
  localparam logic [2:0] CODE_CONDITIONS   = 3'd2;
  localparam logic [2:0] CODE_SEQUENCE     = 3'd3;
  localparam logic [2:0] CODE_PROGRAMMING  = 3'd4;
  localparam logic [2:0] CODE_NOT_ACCEPTED = 3'd5;

  localparam logic [1:0] REG_MAX_IMAGE_SIZE   = 2'd0;
  localparam logic [1:0] REG_MAX_BLOCK_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_BLOCK_DATA   = 2'd2;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        len_short;    // download below 11 bytes, or header below 3
    logic        fmt_size_bad; // format, zero size or size above limit
    logic        data_over;    // header payload above max_block_data
    logic        exit_crc;     // exit carries a CRC
    logic [11:0] payload_len;  // header payload length
    logic [31:0] size;
    logic [7:0]  seq;
    logic [7:0]  data;
    logic [31:0] check;
  } udsdl_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/udsdl_front.sv
// Front end: accept a transaction, classify it and queue it for the back end.
`default_nettype none
module udsdl_front import udsdl_pkg::*; #(
  parameter int LENGTH_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             cmd,
  input  wire logic [LENGTH_BITS-1:0] request_length,
  input  wire logic [7:0]             format_id,
  input  wire logic [31:0]            image_size,
  input  wire logic [7:0]             sequence_req,
  input  wire logic [7:0]             data_byte,
  input  wire logic [31:0]            check_value,
  input  wire logic [31:0]            max_image_size,
  input  wire logic [11:0]            max_block_data,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output udsdl_item_t                 q_item
);
  // Two-entry queue.
  udsdl_item_t mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  udsdl_item_t cls;
  logic [LENGTH_BITS:0] plen;
  logic push, pop;

  always_comb begin
    plen = {1'b0, request_length} - (LENGTH_BITS+1)'(2);
    cls = '0;
    cls.cmd = cmd;
    cls.size = image_size;
    cls.seq = sequence_req;
    cls.data = data_byte;
    cls.check = check_value;
    cls.exit_crc = (request_length == LENGTH_BITS'(EXIT_CRC_LENGTH));
    cls.payload_len = 12'(plen);
    cls.data_over = ({{(32-LENGTH_BITS-1){1'b0}}, plen} > {20'd0, max_block_data});
    if (cmd == CMD_DOWNLOAD) begin
      cls.len_short = (request_length < LENGTH_BITS'(DOWNLOAD_MIN_LENGTH));
    end else begin
      cls.len_short = (request_length < LENGTH_BITS'(3));
    end
    cls.fmt_size_bad = (format_id != FORMAT_REQUIRED) || (image_size == 32'd0) ||
                       (image_size > max_image_size);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/udsdl_back.sv
// Back end: session state, CRC and the registered result stage.
`default_nettype none
module udsdl_back import udsdl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire udsdl_item_t q_item,
  input  wire logic [11:0] max_block_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             resp_valid,
  output logic [7:0]       resp_sid,
  output logic [7:0]       rejected_sid,
  output logic [2:0]       reject_code,
  output logic [7:0]       echo_sequence,
  output logic [11:0]      block_limit,
  output logic             write_valid,
  output logic [7:0]       write_data,
  output logic [1:0]       session_state
);
  logic [1:0]  phase, phase_next;
  logic [31:0] announced_size, announced_size_next;
  logic [31:0] received_count, received_count_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic [31:0] crc_register, crc_register_next;
  logic [11:0] block_bytes_left, block_bytes_left_next;
  logic        rv, wv;
  logic [7:0]  sid, rsid, eseq, wdata;
  logic [2:0]  code;
  logic [11:0] blim;
  logic        go, clr, active;

  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;
  assign active = (phase == PHASE_ACTIVE);

  always_comb begin
    phase_next = phase;
    announced_size_next = announced_size;
    received_count_next = received_count;
    expected_sequence_next = expected_sequence;
    crc_register_next = crc_register;
    block_bytes_left_next = block_bytes_left;
    rv = 1'b0; wv = 1'b0; sid = '0; rsid = '0; eseq = '0; wdata = '0;
    code = CODE_NONE; blim = '0; clr = 1'b0;
    unique case (q_item.cmd)
      CMD_DOWNLOAD: begin
        rv = 1'b1;
        if (active) begin
          sid = SID_NEGATIVE; rsid = SID_DOWNLOAD; code = CODE_NOT_ACCEPTED;
        end else if (q_item.len_short || q_item.fmt_size_bad) begin
          sid = SID_NEGATIVE; rsid = SID_DOWNLOAD; code = CODE_RANGE;
        end else begin
          clr = 1'b1;
          phase_next = PHASE_ACTIVE;
          sid = SID_DOWNLOAD + POSITIVE_OFFSET;
          blim = max_block_length;
        end
      end
      CMD_HEADER: begin
        rv = 1'b1;
        block_bytes_left_next = '0;
        if (!active) begin
          sid = SID_NEGATIVE; rsid = SID_TRANSFER; code = CODE_CONDITIONS;
        end else if (q_item.len_short || q_item.data_over) begin
          sid = SID_NEGATIVE; rsid = SID_TRANSFER; code = CODE_RANGE;
        end else if (q_item.seq != expected_sequence) begin
          sid = SID_NEGATIVE; rsid = SID_TRANSFER; code = CODE_SEQUENCE;
        end else begin
          block_bytes_left_next = q_item.payload_len;
          expected_sequence_next = q_item.seq + 8'd1;
          sid = SID_TRANSFER + POSITIVE_OFFSET;
          eseq = q_item.seq;
        end
      end
      CMD_DATA: begin
        if (active && block_bytes_left != 12'd0) begin
          crc_register_next = crc_byte(crc_register, q_item.data);
          received_count_next = received_count + 32'd1;
          block_bytes_left_next = block_bytes_left - 12'd1;
          wv = 1'b1;
          wdata = q_item.data;
        end
      end
      default: begin
        rv = 1'b1;
        block_bytes_left_next = '0;
        if (!active) begin
          sid = SID_NEGATIVE; rsid = SID_EXIT; code = CODE_CONDITIONS;
        end else if (received_count != announced_size) begin
          phase_next = PHASE_FAILED; clr = 1'b1;
          sid = SID_NEGATIVE; rsid = SID_EXIT; code = CODE_CONDITIONS;
        end else if (q_item.exit_crc && ((crc_register ^ CRC_INIT) != q_item.check)) begin
          phase_next = PHASE_FAILED; clr = 1'b1;
          sid = SID_NEGATIVE; rsid = SID_EXIT; code = CODE_PROGRAMMING;
        end else begin
          phase_next = PHASE_COMPLETE; clr = 1'b1;
          sid = SID_EXIT + POSITIVE_OFFSET;
        end
      end
    endcase
    if (clr) begin
      announced_size_next = (q_item.cmd == CMD_DOWNLOAD) ? q_item.size : 32'd0;
      received_count_next = '0;
      expected_sequence_next = 8'd1;
      crc_register_next = CRC_INIT;
      block_bytes_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      resp_valid <= rv; resp_sid <= sid; rejected_sid <= rsid; reject_code <= code;
      echo_sequence <= eseq; block_limit <= blim; write_valid <= wv;
      write_data <= wdata; session_state <= phase_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
      phase <= PHASE_IDLE;
      announced_size <= '0;
      received_count <= '0;
      expected_sequence <= 8'd1;
      crc_register <= CRC_INIT;
      block_bytes_left <= '0;
    end else begin
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (go) begin
        phase <= phase_next;
        announced_size <= announced_size_next;
        received_count <= received_count_next;
        expected_sequence <= expected_sequence_next;
        crc_register <= crc_register_next;
        block_bytes_left <= block_bytes_left_next;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/uds_download_session_crc32.sv
// Top level of the UDS download session server with streamed CRC-32.
`default_nettype none
// One transaction in, one result out, one per cycle sustained while out_ready
// holds high. The top level holds the configuration registers; the front end
// classifies each request (length, format and size checks) and holds it in a
// two-entry queue; the back end applies it to the session state, folds data
// bytes into the reflected CRC-32, and drives a registered result stage. A
// transaction passes the queue entry and then the result register before its
// result is presented; the back end's single state update per cycle sets the
// rate. Write configuration only while idle.
module uds_download_session_crc32 import udsdl_pkg::*; #(
  parameter int LENGTH_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             cmd,
  input  wire logic [LENGTH_BITS-1:0] request_length,
  input  wire logic [7:0]             format_id,
  input  wire logic [31:0]            image_size,
  input  wire logic [7:0]             sequence_req,
  input  wire logic [7:0]             data_byte,
  input  wire logic [31:0]            check_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        resp_valid,
  output logic [7:0]                  resp_sid,
  output logic [7:0]                  rejected_sid,
  output logic [2:0]                  reject_code,
  output logic [7:0]                  echo_sequence,
  output logic [11:0]                 block_limit,
  output logic                        write_valid,
  output logic [7:0]                  write_data,
  output logic [1:0]                  session_state
);
  logic [31:0] max_image_size;
  logic [11:0] max_block_length, max_block_data;
  logic        q_valid, q_ready;
  udsdl_item_t q_item;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_image_size   <= 32'd1048576;
      max_block_length <= 12'd4095;
      max_block_data   <= 12'd4093;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_IMAGE_SIZE:   max_image_size <= cfg_data;
        REG_MAX_BLOCK_LENGTH: max_block_length <= cfg_data[11:0];
        REG_MAX_BLOCK_DATA:   max_block_data <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  udsdl_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .request_length, .format_id,
    .image_size, .sequence_req, .data_byte, .check_value, .max_image_size,
    .max_block_data, .q_valid, .q_ready, .q_item
  );

  udsdl_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .max_block_length, .out_valid,
    .out_ready, .resp_valid, .resp_sid, .rejected_sid, .reject_code,
    .echo_sequence, .block_limit, .write_valid, .write_data, .session_state
  );
endmodule
`default_nettype wire

FILE: hw/rtl/udsdl_checker.sv
// Port-level checker for the download session block, bound to the top level.
`default_nettype none
module udsdl_checker import udsdl_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       resp_valid,
  input wire logic [7:0] resp_sid,
  input wire logic [2:0] reject_code,
  input wire logic       write_valid,
  input wire logic [1:0] session_state
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(resp_sid))
    else $error("result changed while stalled");
  a_write_no_resp: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> !resp_valid)
    else $error("write together with a response");
  a_neg_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_valid |-> ((resp_sid == SID_NEGATIVE) == (reject_code != CODE_NONE)))
    else $error("negative id and reject code disagree");
  a_write_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> session_state == PHASE_ACTIVE)
    else $error("write outside an active session");
endmodule

bind uds_download_session_crc32 udsdl_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .resp_valid, .resp_sid, .reject_code,
  .write_valid, .session_state
);
`default_nettype wire

FILE: bench/tb_uds_download_session_crc32.sv
// Self-checking testbench for the UDS download session server with CRC-32.
`timescale 1ns / 100ps
`default_nettype none
module tb_uds_download_session_crc32;
  import udsdl_pkg::*;

  // One expected response transaction.
  typedef struct packed {
    logic        resp_valid;
    logic [7:0]  resp_sid;
    logic [7:0]  rejected_sid;
    logic [2:0]  reject_code;
    logic [7:0]  echo_sequence;
    logic [11:0] block_limit;
    logic        write_valid;
    logic [7:0]  write_data;
    logic [1:0]  session_state;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_MAX_IMAGE_SIZE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_DOWNLOAD;
  logic [11:0] request_length = '0;
  logic [7:0]  format_id = '0;
  logic [31:0] image_size = '0;
  logic [7:0]  sequence_req = '0;
  logic [7:0]  data_byte = '0;
  logic [31:0] check_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        resp_valid;
  logic [7:0]  resp_sid;
  logic [7:0]  rejected_sid;
  logic [2:0]  reject_code;
  logic [7:0]  echo_sequence;
  logic [11:0] block_limit;
  logic        write_valid;
  logic [7:0]  write_data;
  logic [1:0]  session_state;

  uds_download_session_crc32 u_top (.*);

  always #5 clk = ~clk;

  // Shadow of the configuration and the session state.
  logic [31:0] lim_image;
  logic [11:0] lim_blen;
  logic [11:0] lim_bdata;
  logic [1:0]  sess_phase;
  logic [31:0] sess_size;
  logic [31:0] sess_count;
  logic [7:0]  sess_seq;
  logic [31:0] sess_crc;
  logic [11:0] sess_left;

  response_t pending_responses[$];
  int        mismatches;
  int        items_sent;
  int        responses_seen;
  int        writes_seen;
  int        completes_seen;
  int        burst_left;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void reset_transfer();
    sess_size  = '0;
    sess_count = '0;
    sess_seq   = 8'd1;
    sess_crc   = CRC_INIT;
    sess_left  = '0;
  endfunction

  function automatic logic [31:0] fold_crc(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  // Apply one request to the shadow session and return its response.
  function automatic response_t session_step(input logic [1:0] c, input logic [11:0] len,
      input logic [7:0] fmt, input logic [31:0] sz, input logic [7:0] sq,
      input logic [7:0] b, input logic [31:0] chk);
    response_t r;
    r = '0;
    case (c)
      CMD_DOWNLOAD: begin
        r.resp_valid = 1'b1;
        if (sess_phase == PHASE_ACTIVE) begin
          r.resp_sid = SID_NEGATIVE; r.rejected_sid = SID_DOWNLOAD;
          r.reject_code = CODE_NOT_ACCEPTED;
        end else if (len < DOWNLOAD_MIN_LENGTH || fmt != FORMAT_REQUIRED ||
                     sz == 0 || sz > lim_image) begin
          r.resp_sid = SID_NEGATIVE; r.rejected_sid = SID_DOWNLOAD;
          r.reject_code = CODE_RANGE;
        end else begin
          reset_transfer();
          sess_size = sz;
          sess_phase = PHASE_ACTIVE;
          r.resp_sid = SID_DOWNLOAD + POSITIVE_OFFSET;
          r.block_limit = lim_blen;
        end
      end
      CMD_HEADER: begin
        sess_left = '0;
        r.resp_valid = 1'b1;
        r.resp_sid = SID_NEGATIVE;
        r.rejected_sid = SID_TRANSFER;
        if (sess_phase != PHASE_ACTIVE) r.reject_code = CODE_CONDITIONS;
        else if (len < 3 || (len - 12'd2) > lim_bdata) r.reject_code = CODE_RANGE;
        else if (sq != sess_seq) r.reject_code = CODE_SEQUENCE;
        else begin
          sess_left = len - 12'd2;
          sess_seq = sq + 8'd1;
          r.resp_sid = SID_TRANSFER + POSITIVE_OFFSET;
          r.rejected_sid = '0;
          r.echo_sequence = sq;
        end
      end
      CMD_DATA: begin
        if (sess_phase == PHASE_ACTIVE && sess_left != 0) begin
          sess_crc = fold_crc(sess_crc, b);
          sess_count++;
          sess_left--;
          r.write_valid = 1'b1;
          r.write_data = b;
        end
      end
      default: begin
        sess_left = '0;
        r.resp_valid = 1'b1;
        r.resp_sid = SID_NEGATIVE;
        r.rejected_sid = SID_EXIT;
        if (sess_phase != PHASE_ACTIVE) r.reject_code = CODE_CONDITIONS;
        else if (sess_count != sess_size) begin
          sess_phase = PHASE_FAILED; reset_transfer(); r.reject_code = CODE_CONDITIONS;
        end else if (len == EXIT_CRC_LENGTH && (sess_crc ^ CRC_INIT) != chk) begin
          sess_phase = PHASE_FAILED; reset_transfer(); r.reject_code = CODE_PROGRAMMING;
        end else begin
          sess_phase = PHASE_COMPLETE; reset_transfer();
          r.resp_sid = SID_EXIT + POSITIVE_OFFSET; r.rejected_sid = '0;
        end
      end
    endcase
    r.session_state = sess_phase;
    return r;
  endfunction

  // Send one request transaction; the sender runs in bursts with random gaps.
  // Valid stays high between transactions of a burst.
  task automatic send_request(input logic [1:0] c, input logic [11:0] len,
      input logic [7:0] fmt, input logic [31:0] sz, input logic [7:0] sq,
      input logic [7:0] b, input logic [31:0] chk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    cmd <= c; request_length <= len; format_id <= fmt; image_size <= sz;
    sequence_req <= sq; data_byte <= b; check_value <= chk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(session_step(c, len, fmt, sz, sq, b, chk));
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid when the sender stops.
  task automatic stop_sending();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Write one register once every response has drained.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    stop_sending();
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_IMAGE_SIZE:   lim_image = val;
      REG_MAX_BLOCK_LENGTH: lim_blen = val[11:0];
      default:              lim_bdata = val[11:0];
    endcase
  endtask

  // Receiver stall pattern: runs of ready, runs of stall, sometimes steady.
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 12);
      out_ready <= ($urandom_range(0, 2) != 0);
      repeat (run) @(negedge clk);
    end
  end

  // Check each response transaction against the oldest expectation.
  always @(posedge clk) begin
    response_t want;
    if (!rst && out_valid && out_ready) begin
      responses_seen++;
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected response", 0, 0);
      end else begin
        want = pending_responses.pop_front();
        if (write_valid) writes_seen++;
        if (resp_sid == SID_EXIT + POSITIVE_OFFSET) completes_seen++;
        if (resp_valid !== want.resp_valid) report_mismatch("resp_valid", resp_valid, want.resp_valid);
        if (resp_sid !== want.resp_sid) report_mismatch("resp_sid", resp_sid, want.resp_sid);
        if (rejected_sid !== want.rejected_sid)
          report_mismatch("rejected_sid", rejected_sid, want.rejected_sid);
        if (reject_code !== want.reject_code)
          report_mismatch("reject_code", reject_code, want.reject_code);
        if (echo_sequence !== want.echo_sequence)
          report_mismatch("echo_sequence", echo_sequence, want.echo_sequence);
        if (block_limit !== want.block_limit)
          report_mismatch("block_limit", block_limit, want.block_limit);
        if (write_valid !== want.write_valid)
          report_mismatch("write_valid", write_valid, want.write_valid);
        if (write_data !== want.write_data)
          report_mismatch("write_data", write_data, want.write_data);
        if (session_state !== want.session_state)
          report_mismatch("session_state", session_state, want.session_state);
      end
    end
  end

  // Run a download: request, blocks of random bytes, exit, with an optional corrupted CRC.
  task automatic run_download(input int nbytes, input bit with_crc, input bit corrupt);
    int sent;
    int blk;
    logic [7:0]  sq;
    logic [31:0] crc;
    sent = 0;
    sq = 8'd1;
    crc = CRC_INIT;
    send_request(CMD_DOWNLOAD, 12'd11 + $urandom_range(0, 3), FORMAT_REQUIRED, nbytes,
                 $urandom, $urandom, $urandom);
    while (sent < nbytes) begin
      blk = $urandom_range(1, lim_bdata < 8 ? lim_bdata : 8);
      if (blk > nbytes - sent) blk = nbytes - sent;
      send_request(CMD_HEADER, blk + 2, $urandom, $urandom, sq, $urandom, $urandom);
      sq++;
      repeat (blk) begin
        logic [7:0] b;
        b = $urandom;
        crc = fold_crc(crc, b);
        send_request(CMD_DATA, $urandom, $urandom, $urandom, $urandom, b, $urandom);
      end
      sent += blk;
      // Occasional stray or malformed items between blocks.
      if ($urandom_range(0, 9) == 0)
        send_request($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
    end
    send_request(CMD_EXIT, with_crc ? 12'd5 : 12'd1, $urandom, $urandom, $urandom,
                 $urandom, (crc ^ CRC_INIT) ^ {31'd0, corrupt});
  endtask

  task automatic test_directed();
    // Extremes of fields and every rejection path.
    send_request(CMD_DATA, 12'hFFF, 8'hFF, '1, '1, 8'hFF, '1);      // stray byte
    send_request(CMD_HEADER, 12'd5, 0, 0, 8'd1, 0, 0);              // not active
    send_request(CMD_EXIT, 12'd5, 0, 0, 0, 0, 0);                   // not active
    send_request(CMD_DOWNLOAD, 12'd10, FORMAT_REQUIRED, 32'd4, 0, 0, 0); // short
    send_request(CMD_DOWNLOAD, 12'd11, 8'h00, 32'd4, 0, 0, 0);      // bad format
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'd0, 0, 0, 0);
    send_request(CMD_DOWNLOAD, 12'hFFF, FORMAT_REQUIRED, '1, 0, 0, 0);   // too large
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'd3, 0, 0, 0);
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'd3, 0, 0, 0); // while active
    send_request(CMD_HEADER, 12'd2, 0, 0, 8'd1, 0, 0);              // too short
    send_request(CMD_HEADER, 12'hFFF, 0, 0, 8'd1, 0, 0);            // largest block
    send_request(CMD_HEADER, 12'd5, 0, 0, 8'd9, 0, 0);              // wrong sequence
    send_request(CMD_HEADER, 12'd6, 0, 0, 8'd2, 0, 0);              // four bytes open
    send_request(CMD_DATA, 0, 0, 0, 0, 8'h00, 0);
    send_request(CMD_DATA, 0, 0, 0, 0, 8'hFF, 0);
    send_request(CMD_HEADER, 12'd3, 0, 0, 8'd3, 0, 0);              // closes open block
    send_request(CMD_DATA, 0, 0, 0, 0, 8'hA5, 0);
    send_request(CMD_DATA, 0, 0, 0, 0, 8'h5A, 0);                   // dropped
    send_request(CMD_EXIT, 12'd5, 0, 0, 0, 0, 32'h1234_5678);       // CRC mismatch
    send_request(CMD_EXIT, 12'd1, 0, 0, 0, 0, 0);                   // after failure
    run_download(2, 1'b0, 1'b0);                                    // exit without CRC
    run_download(1, 1'b1, 1'b0);
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'd2, 0, 0, 0);
    send_request(CMD_EXIT, 12'd5, 0, 0, 0, 0, 0);                   // count mismatch
  endtask

  task automatic test_sequence_wrap();
    // Enough one-byte blocks to wrap the sequence counter through zero.
    write_register(REG_MAX_BLOCK_DATA, 32'd1);
    run_download(258, 1'b1, 1'b0);
    write_register(REG_MAX_BLOCK_DATA, 32'd4093);
  endtask

  task automatic test_random_sessions(input int target);
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0:       send_request($urandom_range(0, 3), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
        1:       run_download($urandom_range(1, 12), 1'b1, 1'b1);
        2:       run_download($urandom_range(1, 12), $urandom_range(0, 1), 1'b0);
        default: run_download($urandom_range(1, 30), 1'b1, 1'b0);
      endcase
    end
  endtask

  task automatic test_configuration();
    write_register(REG_MAX_IMAGE_SIZE, 32'd1);
    write_register(REG_MAX_BLOCK_LENGTH, 32'd3);
    write_register(REG_MAX_BLOCK_DATA, 32'd1);
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'd2, 0, 0, 0); // over limit
    run_download(1, 1'b1, 1'b0);
    write_register(REG_MAX_IMAGE_SIZE, 32'hFFFF_FFFF);
    write_register(REG_MAX_BLOCK_DATA, 32'd4093);
    send_request(CMD_DOWNLOAD, 12'd11, FORMAT_REQUIRED, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(CMD_HEADER, 12'd4095, 0, 0, 8'd1, 0, 0);            // largest block
    send_request(CMD_HEADER, 12'd4096 - 12'd1, 0, 0, 8'd2, 0, 0);
    send_request(CMD_EXIT, 12'd1, 0, 0, 0, 0, 0);
    write_register(REG_MAX_BLOCK_LENGTH, 32'd4095);
    write_register(REG_MAX_BLOCK_DATA, 32'd5);
    write_register(REG_MAX_IMAGE_SIZE, 32'd64);
  endtask

  initial begin
    lim_image = 32'd1048576;
    lim_blen  = 12'd4095;
    lim_bdata = 12'd4093;
    sess_phase = PHASE_IDLE;
    reset_transfer();
    mismatches = 0; items_sent = 0; responses_seen = 0;
    writes_seen = 0; completes_seen = 0; burst_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_sequence_wrap();
    test_configuration();
    test_random_sessions(850);

    stop_sending();
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d requests, checked %0d responses, %0d storage writes, %0d clean exits.",
             items_sent, responses_seen, writes_seen, completes_seen);
    $display("Covered rejections, sequence wrap, CRC exits and register extremes.");
    if (mismatches == 0) begin
      $display("uds_download_session_crc32 test passed");
    end else begin
      $display("uds_download_session_crc32 test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("uds_download_session_crc32 test failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/udsdl_pkg.sv
hw/rtl/udsdl_front.sv
hw/rtl/udsdl_back.sv
hw/rtl/uds_download_session_crc32.sv
hw/rtl/udsdl_checker.sv
bench/tb_uds_download_session_crc32.sv
